FILE: rtl/core/gtp_pkg.sv
// Package with the shared types, codes and helper functions of the GUID text parser.
`timescale 1ns / 1ps
package gtp_pkg;

  localparam logic [15:0] ChDash   = 16'h002D;
  localparam logic [15:0] ChLBrace = 16'h007B;
  localparam logic [15:0] ChRBrace = 16'h007D;
  localparam logic [15:0] ChLParen = 16'h0028;
  localparam logic [15:0] ChRParen = 16'h0029;
  localparam logic [15:0] ChComma  = 16'h002C;
  localparam logic [15:0] ChZero   = 16'h0030;
  localparam logic [15:0] ChLowX   = 16'h0078;
  localparam logic [15:0] ChUpX    = 16'h0058;

  localparam logic [5:0] ListOpenBytes = 6'd45;
  localparam logic [5:0] ListCloseTwo  = 6'd46;
  localparam logic [5:0] ListDone      = 6'd47;

  typedef enum logic [1:0] {
    FMT_DASHED = 2'd0,
    FMT_LIST   = 2'd1,
    FMT_PLAIN  = 2'd2
  } fmt_t;

  typedef enum logic [1:0] {
    WRAP_NONE  = 2'd0,
    WRAP_BRACE = 2'd1,
    WRAP_PAREN = 2'd2
  } wrap_t;

  typedef struct packed {
    logic        status;
    fmt_t        format_used;
    logic [31:0] part_one;
    logic [15:0] part_two;
    logic [15:0] part_three;
    logic [63:0] tail_bytes;
  } result_t;

  // Whitespace set: 26 fixed code points.
  function automatic logic is_space(input logic [15:0] c);
    logic r;
    r = (c == 16'h0020) || (c == 16'h1680) || (c == 16'h180E) ||
        (c >= 16'h2000 && c <= 16'h200A) || (c == 16'h202F) ||
        (c == 16'h205F) || (c == 16'h3000) || (c == 16'h2028) ||
        (c == 16'h2029) || (c >= 16'h0009 && c <= 16'h000D) ||
        (c == 16'h0085) || (c == 16'h00A0);
    return r;
  endfunction

  // Hex digit decode: bit 4 set means the code is a digit.
  function automatic logic [4:0] hex_of(input logic [15:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 16'h0030 && c <= 16'h0039) r = {1'b1, c[3:0]};
    else if ((c >= 16'h0061 && c <= 16'h0066) || (c >= 16'h0041 && c <= 16'h0046))
      r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

endpackage

FILE: rtl/core/gtp_if.sv
// Valid/ready channel interfaces for code words and result words.
`timescale 1ns / 1ps
interface gtp_code_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [15:0] code;
  modport source (output valid, output code, input ready);
  modport sink   (input valid, input code, output ready);
endinterface

interface gtp_result_if (input logic clk);
  logic               valid;
  logic               ready;
  gtp_pkg::result_t   res;
  modport source (output valid, output res, input ready);
  modport sink   (input valid, input res, output ready);
endinterface

FILE: rtl/core/guid_text_parser_unit.sv
// Top level of the GUID text parser: trimming, dashed and plain parsers, list parser instance, result register.
// A terminator word's result word is registered and offered in the cycle after acceptance.
// Throughput: one code word per cycle, save for the hold-off below; each non-space word updates all parsers at once.
// The result register stands between the sides, so input keeps flowing while a result waits,
// except that a terminator is held off while an untaken result still occupies the register.
// Reset (synchronous, rst_n low) clears all parser state and empties the result register.
`timescale 1ns / 1ps
module guid_text_parser_unit (
  input logic clk,
  input logic rst_n,
  gtp_code_if.sink     in_ch,
  gtp_result_if.source out_ch
);

  logic        out_valid_r;
  gtp_pkg::result_t res_r, res_nxt;

  logic        seen_r, pend_r, dash_r, brace_r;
  logic [5:0]  dpos_r, dpos_nxt;
  gtp_pkg::wrap_t wrap_r, wrap_nxt;
  logic [63:0] dhi_r, dlo_r, dhi_nxt, dlo_nxt;
  logic        dfail_r, dfail_nxt;
  logic [5:0]  pcnt_r, pcnt_nxt;
  logic [63:0] phi_r, plo_r, phi_nxt, plo_nxt;
  logic        pfail_r, pfail_nxt;

  logic        acc, term, sp, step;
  logic [15:0] c;
  logic [4:0]  hx;
  logic        lfail, ldone;
  logic [63:0] lhi, llo;
  logic        ok;
  logic [63:0] vhi, vlo;

  assign in_ch.ready = !(out_valid_r && !out_ch.ready) || (in_ch.code != 16'd0);
  assign acc  = in_ch.valid && in_ch.ready;
  assign c    = in_ch.code;
  assign term = acc && (c == 16'd0);
  assign sp   = gtp_pkg::is_space(c);
  assign step = acc && (c != 16'd0) && !sp;
  assign hx   = gtp_pkg::hex_of(c);

  gtp_list_parser u_list (
    .clk(clk), .rst_n(rst_n), .step(step), .clear(term), .code(c),
    .failed(lfail), .done(ldone), .val_hi(lhi), .val_lo(llo)
  );

  // Dashed and plain parsers for one non-space character.
  always_comb begin
    dpos_nxt  = dpos_r;
    wrap_nxt  = wrap_r;
    dhi_nxt   = dhi_r;
    dlo_nxt   = dlo_r;
    dfail_nxt = dfail_r | pend_r;
    pcnt_nxt  = pcnt_r;
    phi_nxt   = phi_r;
    plo_nxt   = plo_r;
    pfail_nxt = pfail_r | pend_r;
    if (!seen_r && (c == gtp_pkg::ChLBrace || c == gtp_pkg::ChLParen)) begin
      wrap_nxt = (c == gtp_pkg::ChLBrace) ? gtp_pkg::WRAP_BRACE : gtp_pkg::WRAP_PAREN;
    end else if (!dfail_nxt) begin
      if (dpos_r < 6'd36) begin
        if (dpos_r == 6'd8 || dpos_r == 6'd13 || dpos_r == 6'd18 || dpos_r == 6'd23) begin
          if (c != gtp_pkg::ChDash) dfail_nxt = 1'b1;
          else dpos_nxt = dpos_r + 6'd1;
        end else if (!hx[4]) begin
          dfail_nxt = 1'b1;
        end else begin
          dhi_nxt  = {dhi_r[59:0], dlo_r[63:60]};
          dlo_nxt  = {dlo_r[59:0], hx[3:0]};
          dpos_nxt = dpos_r + 6'd1;
        end
      end else if (dpos_r == 6'd36 && wrap_r != gtp_pkg::WRAP_NONE) begin
        if (c != ((wrap_r == gtp_pkg::WRAP_BRACE) ? gtp_pkg::ChRBrace : gtp_pkg::ChRParen))
          dfail_nxt = 1'b1;
        else dpos_nxt = 6'd37;
      end else begin
        dfail_nxt = 1'b1;
      end
    end
    if (!pfail_nxt) begin
      if (pcnt_r >= 6'd32 || !hx[4]) begin
        pfail_nxt = 1'b1;
      end else begin
        phi_nxt  = {phi_r[59:0], plo_r[63:60]};
        plo_nxt  = {plo_r[59:0], hx[3:0]};
        pcnt_nxt = pcnt_r + 6'd1;
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n || term) begin
      seen_r <= 1'b0; pend_r <= 1'b0; dash_r <= 1'b0; brace_r <= 1'b0;
      dpos_r <= 6'd0; wrap_r <= gtp_pkg::WRAP_NONE; dhi_r <= 64'd0; dlo_r <= 64'd0;
      dfail_r <= 1'b0; pcnt_r <= 6'd0; phi_r <= 64'd0; plo_r <= 64'd0; pfail_r <= 1'b0;
    end else if (acc && sp) begin
      if (seen_r) pend_r <= 1'b1;
    end else if (step) begin
      seen_r  <= 1'b1;
      pend_r  <= 1'b0;
      if (c == gtp_pkg::ChDash) dash_r <= 1'b1;
      if (c == gtp_pkg::ChLBrace) brace_r <= 1'b1;
      dpos_r  <= dpos_nxt; wrap_r <= wrap_nxt; dhi_r <= dhi_nxt; dlo_r <= dlo_nxt;
      dfail_r <= dfail_nxt; pcnt_r <= pcnt_nxt; phi_r <= phi_nxt; plo_r <= plo_nxt;
      pfail_r <= pfail_nxt;
    end
  end

  // Choose a parser at the terminator and build the result word.
  always_comb begin
    res_nxt = '0;
    if (dash_r) begin
      res_nxt.format_used = gtp_pkg::FMT_DASHED;
      ok  = !dfail_r && dpos_r == ((wrap_r != gtp_pkg::WRAP_NONE) ? 6'd37 : 6'd36);
      vhi = dhi_r; vlo = dlo_r;
    end else if (brace_r) begin
      res_nxt.format_used = gtp_pkg::FMT_LIST;
      ok  = !lfail && ldone;
      vhi = lhi; vlo = llo;
    end else begin
      res_nxt.format_used = gtp_pkg::FMT_PLAIN;
      ok  = !pfail_r && pcnt_r == 6'd32;
      vhi = phi_r; vlo = plo_r;
    end
    res_nxt.status = !ok;
    if (ok) begin
      res_nxt.part_one   = vhi[63:32];
      res_nxt.part_two   = vhi[31:16];
      res_nxt.part_three = vhi[15:0];
      res_nxt.tail_bytes = vlo;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (term) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (term) res_r <= res_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.res   = res_r;

endmodule

FILE: rtl/core/gtp_list_parser.sv
// Braced hex-list parser: phase update and field capture for one character.
`timescale 1ns / 1ps
module gtp_list_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic        clear,
  input  logic [15:0] code,
  output logic        failed,
  output logic        done,
  output logic [63:0] val_hi,
  output logic [63:0] val_lo
);

  logic [5:0]  phase_r, phase_nxt;
  logic [3:0]  sig_r, sig_nxt;
  logic [31:0] field_r, field_nxt;
  logic [63:0] hi_r, hi_nxt, lo_r, lo_nxt;
  logic        fail_r, fail_nxt;

  logic [4:0]  hx;
  logic [5:0]  pm1;
  logic [3:0]  k;
  logic [1:0]  sub;
  logic [3:0]  cap;
  logic [3:0]  sig_inc;
  logic [5:0]  shamt;

  assign failed = fail_r;
  assign done   = (phase_r == gtp_pkg::ListDone);
  assign val_hi = hi_r;
  assign val_lo = lo_r;

  // Next phase, field and stored value for one non-space character.
  always_comb begin
    hx        = gtp_pkg::hex_of(code);
    pm1       = phase_r - 6'd1;
    k         = pm1[5:2];
    sub       = pm1[1:0];
    cap       = (k == 4'd0) ? 4'd8 : ((k <= 4'd2) ? 4'd4 : 4'd2);
    sig_inc   = sig_r + 4'd1;
    // Byte slots three to ten sit at bit offsets 56 down to 0.
    shamt     = {3'(4'd10 - k), 3'd0};
    phase_nxt = phase_r;
    sig_nxt   = sig_r;
    field_nxt = field_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    fail_nxt  = fail_r;
    if (step && !fail_r) begin
      if (phase_r == 6'd0) begin
        if (code == gtp_pkg::ChLBrace) phase_nxt = 6'd1; else fail_nxt = 1'b1;
      end else if (phase_r == gtp_pkg::ListOpenBytes) begin
        if (code == gtp_pkg::ChLBrace) phase_nxt = 6'd13; else fail_nxt = 1'b1;
      end else if (phase_r == gtp_pkg::ListCloseTwo) begin
        if (code == gtp_pkg::ChRBrace) phase_nxt = gtp_pkg::ListDone;
        else fail_nxt = 1'b1;
      end else if (phase_r >= gtp_pkg::ListDone) begin
        fail_nxt = 1'b1;
      end else if (sub == 2'd0) begin
        if (code == gtp_pkg::ChZero) phase_nxt = phase_r + 6'd1; else fail_nxt = 1'b1;
      end else if (sub == 2'd1) begin
        if (code == gtp_pkg::ChLowX || code == gtp_pkg::ChUpX) begin
          phase_nxt = phase_r + 6'd1;
          sig_nxt   = 4'd0;
          field_nxt = 32'd0;
        end else begin
          fail_nxt = 1'b1;
        end
      end else if (hx[4]) begin
        if (sig_r != 4'd0 || hx[3:0] != 4'd0) begin
          sig_nxt = sig_inc;
          if (sig_inc > cap) fail_nxt = 1'b1;
        end
        if (!fail_nxt) begin
          field_nxt = {field_r[27:0], hx[3:0]};
          if (sub == 2'd2) phase_nxt = phase_r + 6'd1;
        end
      end else if (sub == 2'd2) begin
        fail_nxt = 1'b1;
      end else begin
        // End of a field: merge it into its slot, then expect the next.
        unique case (k)
          4'd0:    hi_nxt = hi_r | {field_r, 32'd0};
          4'd1:    hi_nxt = hi_r | {32'd0, field_r[15:0], 16'd0};
          4'd2:    hi_nxt = hi_r | {48'd0, field_r[15:0]};
          default: if (k <= 4'd10) lo_nxt = lo_r | ({56'd0, field_r[7:0]} << shamt);
        endcase
        if (k < 4'd10 && code == gtp_pkg::ChComma)
          phase_nxt = (k == 4'd2) ? gtp_pkg::ListOpenBytes : 6'(({2'd0, k} + 6'd1) * 6'd4 + 6'd1);
        else if (k == 4'd10 && code == gtp_pkg::ChRBrace)
          phase_nxt = gtp_pkg::ListCloseTwo;
        else
          fail_nxt = 1'b1;
      end
    end
  end

  // State registers; cleared after each terminator.
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      phase_r <= 6'd0;
      sig_r   <= 4'd0;
      field_r <= 32'd0;
      hi_r    <= 64'd0;
      lo_r    <= 64'd0;
      fail_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      sig_r   <= sig_nxt;
      field_r <= field_nxt;
      hi_r    <= hi_nxt;
      lo_r    <= lo_nxt;
      fail_r  <= fail_nxt;
    end
  end

endmodule

FILE: rtl/core/gtp_checker.sv
// Port-level checker for the GUID text parser, bound to the top level.
`timescale 1ns / 1ps
module gtp_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic [15:0] in_code,
  input logic out_valid,
  input logic out_ready,
  input gtp_pkg::result_t out_res
);

  // A terminator always yields a result word in the next cycle.
  a_term_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_code == 16'd0 |=> out_valid) else $error("no result");

  // Failed results carry a zero first part and zero tail bytes.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.status |-> out_res.part_one == 32'd0 &&
    out_res.tail_bytes == 64'd0) else $error("value on failure");

  // Format code is never the unused one.
  a_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_res.format_used != 2'd3) else $error("bad format");

  // A waiting result holds steady.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_res)) else $error("result dropped");

endmodule

bind guid_text_parser_unit gtp_checker u_gtp_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_code(in_ch.code),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_res(out_ch.res)
);

FILE: tb/guid_text_parser_checker.sv
// Checker for the GUID text parser: watches both channels, predicts results and compares them.
`timescale 1ns / 1ps
module guid_text_parser_checker (
  input  logic        clk,
  input  logic        rst_n,
  gtp_code_if.sink    in_mon,
  gtp_result_if.sink  out_mon,
  output int          fail_count,
  output int          pending_count
);
  import gtp_pkg::*;

  localparam logic [2:0] FailDash  = 3'b001;
  localparam logic [2:0] FailList  = 3'b010;
  localparam logic [2:0] FailPlain = 3'b100;

  // Parser state, mirroring the block.
  logic        seen_content, pending_space, saw_dash, saw_brace;
  logic [5:0]  dash_pos;
  wrap_t       dash_wrap;
  logic [127:0] dash_val, plain_val, list_val;
  logic [5:0]  plain_cnt, list_ph;
  logic [3:0]  list_sig;
  logic [31:0] list_fld;
  logic [2:0]  failed;

  result_t guid_results_q[$];

  function automatic logic space_code(input logic [15:0] c);
    return c == 16'h0020 || c == 16'h1680 || c == 16'h180E ||
           (c >= 16'h2000 && c <= 16'h200A) || c == 16'h202F || c == 16'h205F ||
           c == 16'h3000 || c == 16'h2028 || c == 16'h2029 ||
           (c >= 16'h0009 && c <= 16'h000D) || c == 16'h0085 || c == 16'h00A0;
  endfunction

  // Returns -1 when the code is not a hex digit.
  function automatic int digit_of(input logic [15:0] c);
    if (c >= 16'h30 && c <= 16'h39) return int'(c - 16'h30);
    if (c >= 16'h61 && c <= 16'h66) return int'(c - 16'h61) + 10;
    if (c >= 16'h41 && c <= 16'h46) return int'(c - 16'h41) + 10;
    return -1;
  endfunction

  task automatic clear_parsers();
    seen_content = 0; pending_space = 0; saw_dash = 0; saw_brace = 0;
    dash_pos = 0; dash_wrap = WRAP_NONE; dash_val = 0; plain_val = 0; list_val = 0;
    plain_cnt = 0; list_ph = 0; list_sig = 0; list_fld = 0; failed = 0;
  endtask

  task automatic dashed_step(input logic [15:0] c);
    int d;
    d = digit_of(c);
    if (failed & FailDash) return;
    if (dash_pos < 36) begin
      if (dash_pos == 8 || dash_pos == 13 || dash_pos == 18 || dash_pos == 23) begin
        if (c != ChDash) begin failed |= FailDash; return; end
      end else begin
        if (d < 0) begin failed |= FailDash; return; end
        dash_val = {dash_val[123:0], 4'(d)};
      end
      dash_pos++;
    end else if (dash_pos == 36 && dash_wrap != WRAP_NONE) begin
      if (c != ((dash_wrap == WRAP_BRACE) ? ChRBrace : ChRParen)) begin
        failed |= FailDash; return;
      end
      dash_pos = 37;
    end else begin
      failed |= FailDash;
    end
  endtask

  task automatic list_step(input logic [15:0] c);
    int d, k, sub, cap;
    d = digit_of(c);
    if (failed & FailList) return;
    if (list_ph == 0) begin
      if (c == ChLBrace) list_ph = 1; else failed |= FailList;
      return;
    end
    if (list_ph == ListOpenBytes) begin
      if (c == ChLBrace) list_ph = 13; else failed |= FailList;
      return;
    end
    if (list_ph == ListCloseTwo) begin
      if (c == ChRBrace) list_ph = ListDone; else failed |= FailList;
      return;
    end
    if (list_ph >= ListDone) begin failed |= FailList; return; end
    k = (list_ph - 1) / 4;
    sub = (list_ph - 1) % 4;
    cap = (k == 0) ? 8 : (k < 3) ? 4 : 2;
    if (sub == 0) begin
      if (c == ChZero) list_ph++; else failed |= FailList;
    end else if (sub == 1) begin
      if (c == ChLowX || c == ChUpX) begin
        list_ph++; list_sig = 0; list_fld = 0;
      end else failed |= FailList;
    end else if (d >= 0) begin
      if (list_sig > 0 || d != 0) begin
        list_sig++;
        if (list_sig > cap) begin failed |= FailList; return; end
      end
      list_fld = {list_fld[27:0], 4'(d)};
      if (sub == 2) list_ph++;
    end else if (sub == 2) begin
      failed |= FailList;
    end else begin
      // Field closed: place it in the value.
      if (k == 0) list_val[127:96] |= list_fld;
      else if (k == 1) list_val[95:80] |= list_fld[15:0];
      else if (k == 2) list_val[79:64] |= list_fld[15:0];
      else list_val[63:0] |= 64'(list_fld[7:0]) << (8 * (10 - k));
      if (k < 10 && c == ChComma) list_ph = (k == 2) ? ListOpenBytes : 6'(1 + 4 * (k + 1));
      else if (k == 10 && c == ChRBrace) list_ph = ListCloseTwo;
      else failed |= FailList;
    end
  endtask

  task automatic parse_code(input logic [15:0] c);
    result_t r;
    logic ok;
    logic [127:0] v;
    if (c == 16'h0000) begin
      if (saw_dash) begin
        r.format_used = FMT_DASHED; v = dash_val;
        ok = !(failed & FailDash) && dash_pos == ((dash_wrap != WRAP_NONE) ? 37 : 36);
      end else if (saw_brace) begin
        r.format_used = FMT_LIST; v = list_val;
        ok = !(failed & FailList) && list_ph == ListDone;
      end else begin
        r.format_used = FMT_PLAIN; v = plain_val;
        ok = !(failed & FailPlain) && plain_cnt == 32;
      end
      if (!ok) v = 0;
      r.status = !ok;
      r.part_one = v[127:96]; r.part_two = v[95:80];
      r.part_three = v[79:64]; r.tail_bytes = v[63:0];
      guid_results_q.push_back(r);
      clear_parsers();
      return;
    end
    if (space_code(c)) begin
      if (seen_content) pending_space = 1;
      return;
    end
    if (pending_space) begin
      failed |= FailDash | FailPlain;
      pending_space = 0;
    end
    if (c == ChDash) saw_dash = 1;
    if (c == ChLBrace) saw_brace = 1;
    if (!seen_content && (c == ChLBrace || c == ChLParen))
      dash_wrap = (c == ChLBrace) ? WRAP_BRACE : WRAP_PAREN;
    else
      dashed_step(c);
    seen_content = 1;
    if (!(failed & FailPlain)) begin
      if (plain_cnt >= 32 || digit_of(c) < 0) failed |= FailPlain;
      else begin
        plain_val = {plain_val[123:0], 4'(digit_of(c))};
        plain_cnt++;
      end
    end
    list_step(c);
  endtask

  initial begin
    clear_parsers();
    fail_count = 0;
  end

  assign pending_count = guid_results_q.size();

  // Compare each result word with the oldest prediction, then predict from the code word.
  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n) begin
      if (out_mon.valid && out_mon.ready) begin
        if (guid_results_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("Unexpected result word %h", out_mon.res);
        end else begin
          exp_r = guid_results_q.pop_front();
          if (exp_r !== out_mon.res) begin
            fail_count++;
            if (fail_count <= 10)
              $display("Result mismatch: expected %h, got %h", exp_r, out_mon.res);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) parse_code(in_mon.code);
    end
  end
endmodule

FILE: tb/testbench.sv
// Top of the GUID text parser testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
  import gtp_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  int   fail_count, pending_count;
  int   cycle_count = 0;
  int   strings_sent = 0;
  bit   stall_long = 0;
  bit   burst_mode = 1;
  logic [15:0] guid_text[$];

  gtp_code_if   code_ch (clk);
  gtp_result_if res_ch (clk);

  guid_text_parser_unit u_top (.clk(clk), .rst_n(rst_n), .in_ch(code_ch.sink),
                               .out_ch(res_ch.source));
  guid_text_parser_checker u_chk (.clk(clk), .rst_n(rst_n), .in_mon(code_ch.sink),
                                  .out_mon(res_ch.sink), .fail_count(fail_count),
                                  .pending_count(pending_count));

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver stall pattern, with one long hold-off when asked.
  initial begin
    int ph;
    res_ch.ready = 0;
    ph = 0;
    forever begin
      @(negedge clk);
      ph++;
      if (stall_long) res_ch.ready <= 0;
      else if ((ph / 64) % 3 == 0) res_ch.ready <= 1;
      else res_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  function automatic logic [15:0] hex_code(input logic [3:0] n, input bit upper);
    if (n < 10) return 16'h30 + n;
    return (upper ? 16'h41 : 16'h61) + n - 10;
  endfunction

  function automatic logic [15:0] rand_space();
    logic [15:0] ws[26] = '{16'h0020, 16'h1680, 16'h180E, 16'h2000, 16'h2001, 16'h2002,
      16'h2003, 16'h2004, 16'h2005, 16'h2006, 16'h2007, 16'h2008, 16'h2009, 16'h200A,
      16'h202F, 16'h205F, 16'h3000, 16'h2028, 16'h2029, 16'h0009, 16'h000A, 16'h000B,
      16'h000C, 16'h000D, 16'h0085, 16'h00A0};
    return ws[$urandom_range(0, 25)];
  endfunction

  task automatic add_hex(input int n, input logic [127:0] v, input int lsb);
    for (int i = n - 1; i >= 0; i--)
      guid_text.push_back(hex_code(v[lsb + 4 * i +: 4], $urandom_range(0, 1)));
  endtask

  // Builds one string of the given form into guid_text, terminator included.
  task automatic build_string(input int form, input bit damage);
    logic [127:0] v;
    int wrap, pos, nz;
    v = {$urandom, $urandom, $urandom, $urandom};
    if ($urandom_range(0, 7) == 0) v = '1;
    if ($urandom_range(0, 7) == 0) v = '0;
    guid_text.delete();
    repeat ($urandom_range(0, 2)) guid_text.push_back(rand_space());
    case (form)
      0: begin
        wrap = $urandom_range(0, 2);
        if (wrap == 1) guid_text.push_back(ChLBrace);
        if (wrap == 2) guid_text.push_back(ChLParen);
        add_hex(8, v, 96); guid_text.push_back(ChDash);
        add_hex(4, v, 80); guid_text.push_back(ChDash);
        add_hex(4, v, 64); guid_text.push_back(ChDash);
        add_hex(4, v, 48); guid_text.push_back(ChDash);
        add_hex(12, v, 0);
        if (wrap == 1) guid_text.push_back(ChRBrace);
        if (wrap == 2) guid_text.push_back(ChRParen);
      end
      1: begin
        guid_text.push_back(ChLBrace);
        for (int k = 0; k < 11; k++) begin
          if (k == 3) guid_text.push_back(ChLBrace);
          guid_text.push_back(ChZero);
          guid_text.push_back($urandom_range(0, 1) ? ChLowX : ChUpX);
          repeat ($urandom_range(0, 2)) guid_text.push_back(ChZero);
          nz = (k == 0) ? 8 : (k < 3) ? 4 : 2;
          if (k == 0) add_hex(nz, v, 96);
          else if (k < 3) add_hex(nz, v, 96 - 16 * k);
          else add_hex(nz, v, 8 * (10 - k));
          if ($urandom_range(0, 4) == 0) guid_text.push_back(rand_space());
          guid_text.push_back((k == 10) ? ChRBrace : ChComma);
        end
        guid_text.push_back(ChRBrace);
      end
      default: add_hex(32, v, 0);
    endcase
    repeat ($urandom_range(0, 2)) guid_text.push_back(rand_space());
    if (damage && guid_text.size() > 0) begin
      pos = $urandom_range(0, guid_text.size() - 1);
      case ($urandom_range(0, 3))
        0: guid_text.delete(pos);
        1: guid_text[pos] = 16'($urandom);
        2: guid_text.insert(pos, rand_space());
        default: guid_text.insert(pos, hex_code(4'($urandom), 0));
      endcase
      for (int i = 0; i < guid_text.size(); i++)
        if (guid_text[i] == 16'h0000) guid_text[i] = 16'h0031;
    end
    guid_text.push_back(16'h0000);
  endtask

  // Sends the built string word by word, with gaps between bursts when burst mode is on.
  task automatic send_string();
    foreach (guid_text[i]) begin
      if (burst_mode && $urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 6)) begin
          code_ch.valid <= 0;
          @(negedge clk);
        end
      code_ch.valid <= 1;
      code_ch.code  <= guid_text[i];
      @(posedge clk);
      while (!code_ch.ready) @(posedge clk);
      @(negedge clk);
    end
    code_ch.valid <= 0;
    strings_sent++;
  endtask

  task automatic send_codes(input logic [15:0] codes[$]);
    guid_text = codes;
    send_string();
  endtask

  initial begin
    code_ch.valid = 0;
    code_ch.code  = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed strings: each form, wrappers, empty and blank strings, invalid codes, inner space, mismatched wrapper.
    send_codes('{16'h0000});
    send_codes('{16'h0020, 16'h3000, 16'h0000});
    send_codes('{16'hFFFF, 16'h8000, 16'h0000});
    build_string(0, 0); send_string();
    build_string(1, 0); send_string();
    build_string(2, 0); send_string();
    send_codes('{16'h0031, 16'h0020, 16'h0032, 16'h0000});
    send_codes('{ChLParen, 16'h0031, ChRBrace, 16'h0000});
    burst_mode = 0;

    // Long receiver hold-off while the sender keeps offering.
    stall_long = 1;
    fork
      begin
        repeat (300) @(negedge clk);
        stall_long = 0;
      end
      for (int i = 0; i < 6; i++) begin build_string(i % 3, 0); send_string(); end
    join
    burst_mode = 1;

    // Random strings, mostly well formed.
    while (strings_sent < 45) begin
      if ($urandom_range(0, 9) == 0) begin
        guid_text.delete();
        repeat ($urandom_range(0, 40)) guid_text.push_back(16'($urandom_range(1, 65535)));
        guid_text.push_back(16'h0000);
      end else build_string($urandom_range(0, 2), $urandom_range(0, 3) == 0);
      send_string();
      // Pause once until everything has drained.
      if (strings_sent == 30) begin
        wait (pending_count == 0);
        @(negedge clk);
      end
    end

    wait (pending_count == 0);
    repeat (20) @(negedge clk);
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
